[rtl/arpc_pkg.sv]
// Package: shared types, constants and codes for the ARP cache engine.
package arpc_pkg;

    localparam int TableEntriesDefault = 32;

    localparam logic [1:0] REQ_RESOLVE = 2'd0;
    localparam logic [1:0] REQ_MESSAGE = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;

    localparam logic [2:0] STS_FOUND   = 3'd0;
    localparam logic [2:0] STS_QUERY   = 3'd1;
    localparam logic [2:0] STS_ERROR   = 3'd2;
    localparam logic [2:0] STS_HANDLED = 3'd3;
    localparam logic [2:0] STS_DROPPED = 3'd4;

    localparam logic [1:0] TXOP_NONE    = 2'd0;
    localparam logic [1:0] TXOP_REQUEST = 2'd1;
    localparam logic [1:0] TXOP_REPLY   = 2'd2;

    localparam logic [1:0] ENT_FREE       = 2'd0;
    localparam logic [1:0] ENT_INCOMPLETE = 2'd1;
    localparam logic [1:0] ENT_RESOLVED   = 2'd2;
    localparam logic [1:0] ENT_STATIC     = 2'd3;

    localparam logic [1:0] CFG_LOCAL_IP  = 2'd0;
    localparam logic [1:0] CFG_LOCAL_MAC = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd2;
    localparam logic [1:0] CFG_IFACE     = 2'd3;

    localparam logic [15:0] HW_ETHER   = 16'h0001;
    localparam logic [15:0] PROTO_IPV4 = 16'h0800;
    localparam logic [15:0] OP_REQUEST = 16'd1;
    localparam logic [10:0] MIN_FRAME  = 11'd28;
    localparam logic [47:0] MAC_BCAST  = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd30;

    typedef enum logic [2:0] {
        CMD_RESOLVE = 3'd0,
        CMD_MESSAGE = 3'd1,
        CMD_TICK    = 3'd2,
        CMD_ERROR   = 3'd3,
        CMD_DROP    = 3'd4
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] pa;
        logic [47:0] smac;
        logic        for_us;
        logic        is_request;
    } job_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [47:0] hw_addr;
        logic [1:0]  tx_op;
        logic [31:0] tx_target_ip;
        logic [47:0] tx_target_mac;
        logic [47:0] tx_dest_mac;
    } result_t;

endpackage

[rtl/arpc_if.sv]
// Interfaces: request, result and configuration channels.
interface arpc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] proto_addr;
    logic [47:0] sender_mac;
    logic [31:0] target_proto_addr;
    logic [15:0] arp_op;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [10:0] frame_length;
    modport source (output valid, req_type, proto_addr, sender_mac, target_proto_addr,
                    arp_op, hw_type, proto_type, frame_length, input ready);
    modport sink (input valid, req_type, proto_addr, sender_mac, target_proto_addr,
                  arp_op, hw_type, proto_type, frame_length, output ready);
endinterface

interface arpc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [47:0] hw_addr;
    logic [1:0]  tx_op;
    logic [31:0] tx_target_ip;
    logic [47:0] tx_target_mac;
    logic [47:0] tx_dest_mac;
    modport source (output valid, status, hw_addr, tx_op, tx_target_ip, tx_target_mac,
                    tx_dest_mac, input ready);
    modport sink (input valid, status, hw_addr, tx_op, tx_target_ip, tx_target_mac,
                  tx_dest_mac, output ready);
endinterface

interface arpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [47:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/arpc_front.sv]
// Front end: accept requests, validate messages and queue classified jobs.
module arpc_front (
    input  logic              clk,
    input  logic              rst_n,
    arpc_req_if.sink          req,
    input  logic [31:0]       local_ip,
    input  logic              iface_on,
    output arpc_pkg::job_t    job,
    output logic              job_valid,
    input  logic              job_ready
);
    import arpc_pkg::*;

    job_t job_in;
    job_t q_reg [2];
    logic wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    always_comb
    begin
        job_in.pa         = req.proto_addr;
        job_in.smac       = req.sender_mac;
        job_in.for_us     = (req.target_proto_addr == local_ip);
        job_in.is_request = (req.arp_op == OP_REQUEST);
        unique case (req.req_type)
            REQ_RESOLVE: job_in.cmd = iface_on ? CMD_RESOLVE : CMD_ERROR;
            REQ_MESSAGE:
                if (req.frame_length < MIN_FRAME || req.hw_type != HW_ETHER
                    || req.proto_type != PROTO_IPV4)
                    job_in.cmd = CMD_DROP;
                else
                    job_in.cmd = CMD_MESSAGE;
            REQ_TICK: job_in.cmd = CMD_TICK;
            default:  job_in.cmd = CMD_ERROR;
        endcase
    end

    assign req.ready = (cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job       = q_reg[rp_reg];
    assign wp_next   = push ? ~wp_reg : wp_reg;
    assign rp_next   = pop ? ~rp_reg : rp_reg;
    assign cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= job_in;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1) else $error("count step");
endmodule

[rtl/arpc_back.sv]
// Back end: scan the entry table, update it and build one result per job.
module arpc_back #(
    parameter int TABLE_ENTRIES = arpc_pkg::TableEntriesDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  arpc_pkg::job_t    job,
    input  logic              job_valid,
    output logic              job_ready,
    input  logic [15:0]       timeout,
    output arpc_pkg::result_t res,
    output logic              res_valid,
    input  logic              res_ready
);
    import arpc_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_WRITE = 5'b00100,
        S_OUT   = 5'b01000,
        S_WAIT  = 5'b10000
    } state_t;

    // state bits live in flip-flops (reset to free); payload in memories
    logic [1:0]  st_reg [TABLE_ENTRIES];
    logic [31:0] ip_mem    [TABLE_ENTRIES];
    logic [47:0] mac_mem   [TABLE_ENTRIES];
    logic [31:0] stamp_mem [TABLE_ENTRIES];

    state_t state_reg, state_next;
    job_t   job_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [IW-1:0] rd_idx_reg;
    logic          rd_v_reg;
    logic [31:0]   rd_ip, rd_stamp;
    logic [47:0]   rd_mac;
    logic [1:0]    rd_st;
    logic [31:0]   now_reg;
    logic          hit_reg, free_reg;
    logic [IW-1:0] hit_idx_reg, vic_idx_reg;
    logic [31:0]   vic_age_reg;
    logic [47:0]   hit_mac_reg;
    logic [1:0]    hit_st_reg;
    logic [31:0]   age;
    result_t       res_reg, res_next;
    logic          do_wr, clr_wr;
    logic [IW-1:0] wr_idx;
    logic [1:0]    wr_st;
    logic [31:0]   wr_ip, wr_stamp;
    logic [47:0]   wr_mac;
    logic          wr_ip_en, wr_mac_en;

    assign job_ready = (state_reg == S_IDLE);
    assign res       = res_reg;
    assign res_valid = (state_reg == S_WAIT);
    assign age       = now_reg - rd_stamp;
    assign rd_st     = st_reg[rd_idx_reg];

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
                if (job_valid)
                begin
                    idx_next = '0;
                    if (job.cmd == CMD_ERROR || job.cmd == CMD_DROP)
                        state_next = S_OUT;
                    else
                        state_next = S_SCAN;
                end
            S_SCAN:
                if (idx_reg == CW'(TABLE_ENTRIES))
                begin
                    if (!rd_v_reg)
                        state_next = (job_reg.cmd == CMD_TICK) ? S_OUT : S_WRITE;
                end
                else
                    idx_next = idx_reg + 1'b1;
            S_WRITE: state_next = S_OUT;
            S_OUT:   state_next = S_WAIT;
            S_WAIT:  if (res_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // tick ages out entries during the scan; resolve/message write in S_WRITE
    always_comb
    begin
        do_wr = 1'b0; clr_wr = 1'b0; wr_idx = rd_idx_reg;
        wr_st = ENT_FREE; wr_ip = '0; wr_mac = '0; wr_stamp = '0;
        wr_ip_en = 1'b1; wr_mac_en = 1'b1;
        if (state_reg == S_SCAN && rd_v_reg && job_reg.cmd == CMD_TICK
            && (rd_st == ENT_INCOMPLETE || rd_st == ENT_RESOLVED)
            && age >= {16'd0, timeout})
        begin
            do_wr = 1'b1; clr_wr = 1'b1;
        end
        else if (state_reg == S_WRITE)
        begin
            wr_stamp = now_reg;
            wr_ip    = job_reg.pa;
            wr_mac   = job_reg.smac;
            if (job_reg.cmd == CMD_RESOLVE)
            begin
                if (!hit_reg)
                begin
                    do_wr = 1'b1; wr_idx = vic_idx_reg; wr_st = ENT_INCOMPLETE;
                    wr_mac_en = 1'b0;
                end
            end
            else if (hit_reg)
            begin
                do_wr = 1'b1; wr_idx = hit_idx_reg; wr_st = ENT_RESOLVED; wr_ip_en = 1'b0;
            end
            else if (job_reg.for_us)
            begin
                do_wr = 1'b1; wr_idx = vic_idx_reg; wr_st = ENT_RESOLVED;
            end
        end
    end

    // build the result from the scan outcome
    always_comb
    begin
        res_next = '0;
        unique case (job_reg.cmd)
            CMD_RESOLVE:
                if (hit_reg && hit_st_reg != ENT_INCOMPLETE)
                begin
                    res_next.status  = STS_FOUND;
                    res_next.hw_addr = hit_mac_reg;
                end
                else
                begin
                    res_next.status       = STS_QUERY;
                    res_next.tx_op        = TXOP_REQUEST;
                    res_next.tx_target_ip = job_reg.pa;
                    res_next.tx_dest_mac  = MAC_BCAST;
                end
            CMD_MESSAGE:
            begin
                res_next.status = STS_HANDLED;
                if (job_reg.for_us && job_reg.is_request)
                begin
                    res_next.tx_op         = TXOP_REPLY;
                    res_next.tx_target_ip  = job_reg.pa;
                    res_next.tx_target_mac = job_reg.smac;
                    res_next.tx_dest_mac   = job_reg.smac;
                end
            end
            CMD_TICK: res_next.status = STS_HANDLED;
            CMD_DROP: res_next.status = STS_DROPPED;
            default:  res_next.status = STS_ERROR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            now_reg   <= '0;
            rd_v_reg  <= 1'b0;
            for (int k = 0; k < TABLE_ENTRIES; k++)
                st_reg[k] <= ENT_FREE;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= (state_reg == S_SCAN) && (idx_reg != CW'(TABLE_ENTRIES));
            if (state_reg == S_IDLE && job_valid && job.cmd == CMD_TICK)
                now_reg <= now_reg + 32'd1;
            if (do_wr)
                st_reg[wr_idx] <= wr_st;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        rd_idx_reg <= idx_reg[IW-1:0];
        rd_ip      <= ip_mem[idx_reg[IW-1:0]];
        rd_mac     <= mac_mem[idx_reg[IW-1:0]];
        rd_stamp   <= stamp_mem[idx_reg[IW-1:0]];
        if (do_wr)
        begin
            if (wr_ip_en || clr_wr) ip_mem[wr_idx] <= wr_ip;
            if (wr_mac_en || clr_wr) mac_mem[wr_idx] <= wr_mac;
            stamp_mem[wr_idx] <= wr_stamp;
        end
    end

    // scan bookkeeping: first match, first free, else oldest entry
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && job_valid)
        begin
            job_reg  <= job;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            vic_idx_reg <= '0;
            vic_age_reg <= '0;
        end
        else if (state_reg == S_SCAN && rd_v_reg)
        begin
            if (!hit_reg && rd_st != ENT_FREE && rd_ip == job_reg.pa)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= rd_idx_reg;
                hit_mac_reg <= rd_mac;
                hit_st_reg  <= rd_st;
            end
            if (!free_reg)
            begin
                if (rd_st == ENT_FREE)
                begin
                    free_reg    <= 1'b1;
                    vic_idx_reg <= rd_idx_reg;
                end
                else if (rd_idx_reg == '0 || age > vic_age_reg)
                begin
                    vic_idx_reg <= rd_idx_reg;
                    vic_age_reg <= age;
                end
            end
        end
        if (state_reg == S_OUT)
            res_reg <= res_next;
    end

    a_wait_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid) else $error("result dropped");
    a_one_state: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !job_ready) else $error("job taken while busy");
endmodule

[rtl/arp_cache_engine_top.sv]
// Top level: ARP cache engine with request, result and configuration channels.
// Usage:
//  - req carries resolve lookups, received ARP messages and one-second ticks.
//    Each transfer on req yields exactly one transfer on rsp, in order.
//  - cfg writes registers: 0 local_ip, 1 local_mac, 2 timeout_seconds,
//    3 iface_ipv4_ethernet. Write only while idle; it is always ready.
//  - A two-deep job queue lets the front keep taking requests while the
//    back end scans the table or rsp is stalled.
//  - A lookup or message passes from the queue through the back end's
//    S_IDLE, S_SCAN, S_WRITE, S_OUT and S_WAIT states; a tick skips
//    S_WRITE, and drops and errors skip S_SCAN and S_WRITE. The scan reads
//    the table memory one entry per cycle. The back end takes no new job
//    until rsp has taken the result of the last one.
//  - A stalled rsp holds its result; the back end waits and the queue
//    then fills and deasserts req.ready.
//  - Reset marks every entry free, clears the clock and restores register
//    defaults (timeout 30, interface on). No clearing pass is needed.
module arp_cache_engine_top #(
    parameter int TABLE_ENTRIES = arpc_pkg::TableEntriesDefault
) (
    input  logic       clk,
    input  logic       rst_n,
    arpc_req_if.sink   req,
    arpc_rsp_if.source rsp,
    arpc_cfg_if.sink   cfg
);
    import arpc_pkg::*;

    logic [31:0] local_ip_reg;
    logic [47:0] local_mac_reg;
    logic [15:0] timeout_reg;
    logic        iface_reg;
    job_t        job;
    logic        job_valid, job_ready;
    result_t     res;

    // config is always ready; local_mac is only held in a register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg  <= '0;
            local_mac_reg <= '0;
            timeout_reg   <= TIMEOUT_RESET;
            iface_reg     <= 1'b1;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_LOCAL_IP:  local_ip_reg  <= cfg.data[31:0];
                CFG_LOCAL_MAC: local_mac_reg <= cfg.data;
                CFG_TIMEOUT:   timeout_reg   <= cfg.data[15:0];
                CFG_IFACE:     iface_reg     <= cfg.data[0];
                default:       iface_reg     <= iface_reg;
            endcase
        end
    end

    arpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .local_ip  (local_ip_reg),
        .iface_on  (iface_reg),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready)
    );

    arpc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .timeout   (timeout_reg),
        .res       (res),
        .res_valid (rsp.valid),
        .res_ready (rsp.ready)
    );

    assign rsp.status        = res.status;
    assign rsp.hw_addr       = res.hw_addr;
    assign rsp.tx_op         = res.tx_op;
    assign rsp.tx_target_ip  = res.tx_target_ip;
    assign rsp.tx_target_mac = res.tx_target_mac;
    assign rsp.tx_dest_mac   = res.tx_dest_mac;

    a_mac_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.valid |=> $stable(local_mac_reg)) else $error("local_mac changed");
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
        else $error("result not held");
    a_timeout_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg.valid |=> $stable(timeout_reg)) else $error("timeout changed");
endmodule
